// File: rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the page cache CLOCK replacement block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int PAGE_W = 20;
  localparam int SLOT_W = 4;
  localparam int CMD_W  = 2;
  localparam int CNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_SLOTS = 1'b1;

  localparam logic MODE_CLOCK   = 1'b0;
  localparam logic MODE_CLOCK_M = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOOK,
    OP_HIT,
    OP_FILL_FREE,
    OP_VSTART,
    OP_VSTEP,
    OP_VEMIT,
    OP_FSTART,
    OP_FEMPTY,
    OP_FSCAN,
    OP_FEMIT,
    OP_FCLEAR
  } dp_op_t;

  typedef struct packed {
    logic hit;
    logic free_found;
    logic victim;
    logic fl_dirty;
    logic fl_final;
    logic ptr_last;
    logic any_dirty;
  } dp_status_t;

endpackage

// File: rtl/core/pcc_ctrl.sv
// ----------------------------------------------------------------------------
// pcc_ctrl
// Sequencer for lookup, fill, victim search and flush of the tag store.
// ----------------------------------------------------------------------------
module pcc_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [pcc_pkg::CMD_W-1:0]          in_command,
  input  pcc_pkg::dp_status_t                status,
  output pcc_pkg::dp_op_t                    op,
  output logic                               busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_LOOK_END,
    S_VSTEP,
    S_VEMIT,
    S_FSCAN,
    S_FEMIT,
    S_FCLEAR
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    op        = pcc_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            pcc_pkg::CMD_READ, pcc_pkg::CMD_WRITE: begin
              op        = pcc_pkg::OP_LOAD;
              state_nxt = S_LOOK;
            end
            pcc_pkg::CMD_FLUSH: begin
              if (status.any_dirty) begin
                op        = pcc_pkg::OP_FSTART;
                state_nxt = S_FSCAN;
              end else begin
                op = pcc_pkg::OP_FEMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        // compare uses the registered tag read, so it lags the read
        if (status.hit) begin
          op        = pcc_pkg::OP_HIT;
          state_nxt = S_IDLE;
        end else begin
          op = pcc_pkg::OP_LOOK;
          if (status.ptr_last) state_nxt = S_LOOK_END;
        end
      end
      S_LOOK_END: begin
        if (status.hit) begin
          op        = pcc_pkg::OP_HIT;
          state_nxt = S_IDLE;
        end else if (status.free_found) begin
          op        = pcc_pkg::OP_FILL_FREE;
          state_nxt = S_IDLE;
        end else begin
          op        = pcc_pkg::OP_VSTART;
          state_nxt = S_VSTEP;
        end
      end
      S_VSTEP: begin
        op = pcc_pkg::OP_VSTEP;
        if (status.victim) state_nxt = S_VEMIT;
      end
      S_VEMIT: begin
        op        = pcc_pkg::OP_VEMIT;
        state_nxt = S_IDLE;
      end
      S_FSCAN: begin
        op = pcc_pkg::OP_FSCAN;
        if (status.fl_dirty) state_nxt = S_FEMIT;
        else if (status.ptr_last) state_nxt = S_FCLEAR;
      end
      S_FEMIT: begin
        op = pcc_pkg::OP_FEMIT;
        if (status.fl_final || status.ptr_last) state_nxt = S_FCLEAR;
        else state_nxt = S_FSCAN;
      end
      S_FCLEAR: begin
        op        = pcc_pkg::OP_FCLEAR;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: rtl/core/pcc_dp.sv
// ----------------------------------------------------------------------------
// pcc_dp
// Tag memory, per-slot valid/use/dirty bits, clock hand and result registers.
// ----------------------------------------------------------------------------
module pcc_dp #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pcc_pkg::dp_op_t               op,
  input  logic [pcc_pkg::CMD_W-1:0]     in_command,
  input  logic [pcc_pkg::PAGE_W-1:0]    in_page_number,
  input  logic                          cfg_mode,
  input  logic [pcc_pkg::CNT_W-1:0]     cfg_slots,
  output pcc_pkg::dp_status_t           status,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [pcc_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_fill_needed,
  output logic                          out_writeback_valid,
  output logic [pcc_pkg::PAGE_W-1:0]    out_writeback_page,
  output logic                          out_last
);

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW     = $clog2(SLOTS + 1);
  localparam int TW     = (PAGE_BITS < pcc_pkg::PAGE_W) ? PAGE_BITS : pcc_pkg::PAGE_W;
  localparam int PAGE_W = pcc_pkg::PAGE_W;
  localparam int SLOT_W = pcc_pkg::SLOT_W;

  logic [TW-1:0]    tag_mem [SLOTS];
  logic [TW-1:0]    tag_q;
  logic             mem_we;
  logic [SW-1:0]    mem_waddr;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOTS-1:0] use_r, use_nxt;
  logic [SLOTS-1:0] dirty_r, dirty_nxt;
  logic [SW-1:0]    hand_r, hand_nxt;
  logic [SW-1:0]    ptr_r, ptr_nxt;
  logic [SW-1:0]    start_r, start_nxt;
  logic [1:0]       pass_r, pass_nxt;
  logic             free_found_r, free_found_nxt;
  logic [SW-1:0]    free_r, free_nxt;
  logic [TW-1:0]    page_r, page_nxt;
  logic             write_r, write_nxt;
  logic             cmp_en_r, cmp_en_nxt;
  logic [SW-1:0]    cmp_idx_r, cmp_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_fill_r, out_fill_nxt;
  logic                  out_wbv_r, out_wbv_nxt;
  logic [PAGE_W-1:0]     out_wbp_r, out_wbp_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [NW-1:0]    win;
  logic [SLOTS-1:0] dv;
  logic [SLOTS-1:0] dv_rest;
  logic             in_win;
  logic [SW-1:0]    ptr_circ;
  logic [SW-1:0]    hand_fill;
  logic [SW-1:0]    fill_slot;
  logic             clearing;
  logic             victim_now;
  logic             hit_now;

  // effective window: zero acts as one, oversize clamps to SLOTS
  always_comb begin
    if (cfg_slots == '0) win = NW'(1);
    else if (32'(cfg_slots) > SLOTS) win = NW'(SLOTS);
    else win = NW'(cfg_slots);
  end

  assign dv       = valid_r & dirty_r;
  assign dv_rest  = dv & ~(SLOTS'(1) << ptr_r);
  assign in_win   = (NW'(ptr_r) < win);
  assign ptr_circ = ((NW'(ptr_r) + NW'(1)) == win) ? '0 : ptr_r + SW'(1);
  assign clearing = (cfg_mode == pcc_pkg::MODE_CLOCK) || pass_r[0];
  assign victim_now = !use_r[ptr_r] &&
                      ((cfg_mode == pcc_pkg::MODE_CLOCK) || !dirty_r[ptr_r] || clearing);
  assign hit_now  = cmp_en_r && valid_r[cmp_idx_r] && (tag_q == page_r);
  assign fill_slot = (op == pcc_pkg::OP_VEMIT) ? ptr_r : free_r;
  assign hand_fill = ((NW'(fill_slot) + NW'(1)) == win) ? '0 : fill_slot + SW'(1);

  always_comb begin
    status.hit        = hit_now;
    status.free_found = free_found_r;
    status.victim     = victim_now;
    status.fl_dirty   = dv[ptr_r];
    status.fl_final   = (dv_rest == '0);
    status.ptr_last   = (32'(ptr_r) == SLOTS - 1);
    status.any_dirty  = |dv;
  end

  always_comb begin
    valid_nxt      = valid_r;
    use_nxt        = use_r;
    dirty_nxt      = dirty_r;
    hand_nxt       = hand_r;
    ptr_nxt        = ptr_r;
    start_nxt      = start_r;
    pass_nxt       = pass_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    page_nxt       = page_r;
    write_nxt      = write_r;
    cmp_en_nxt     = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_slot;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_fill_nxt   = out_fill_r;
    out_wbv_nxt    = out_wbv_r;
    out_wbp_nxt    = out_wbp_r;
    out_last_nxt   = out_last_r;

    case (op)
      pcc_pkg::OP_LOAD: begin
        page_nxt       = in_page_number[TW-1:0];
        write_nxt      = (in_command == pcc_pkg::CMD_WRITE);
        ptr_nxt        = '0;
        free_found_nxt = 1'b0;
      end
      pcc_pkg::OP_LOOK: begin
        cmp_en_nxt  = 1'b1;
        cmp_idx_nxt = ptr_r;
        if (!free_found_r && in_win && !valid_r[ptr_r]) begin
          free_found_nxt = 1'b1;
          free_nxt       = ptr_r;
        end
        ptr_nxt = ptr_r + SW'(1);
      end
      pcc_pkg::OP_HIT: begin
        use_nxt[cmp_idx_r] = 1'b1;
        if (write_r) dirty_nxt[cmp_idx_r] = 1'b1;
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b1;
        out_slot_nxt  = SLOT_W'(cmp_idx_r);
        out_fill_nxt  = 1'b0;
        out_wbv_nxt   = 1'b0;
        out_wbp_nxt   = '0;
        out_last_nxt  = 1'b1;
      end
      pcc_pkg::OP_FILL_FREE, pcc_pkg::OP_VEMIT: begin
        mem_we               = 1'b1;
        valid_nxt[fill_slot] = 1'b1;
        use_nxt[fill_slot]   = 1'b1;
        dirty_nxt[fill_slot] = write_r;
        hand_nxt             = hand_fill;
        out_valid_nxt        = 1'b1;
        out_hit_nxt          = 1'b0;
        out_slot_nxt         = SLOT_W'(fill_slot);
        out_fill_nxt         = 1'b1;
        out_last_nxt         = 1'b1;
        if ((op == pcc_pkg::OP_VEMIT) && dirty_r[fill_slot]) begin
          out_wbv_nxt = 1'b1;
          out_wbp_nxt = PAGE_W'(tag_q);
        end else begin
          out_wbv_nxt = 1'b0;
          out_wbp_nxt = '0;
        end
      end
      pcc_pkg::OP_VSTART: begin
        // a hand outside the window starts at slot zero
        if (NW'(hand_r) < win) begin
          ptr_nxt   = hand_r;
          start_nxt = hand_r;
        end else begin
          ptr_nxt   = '0;
          start_nxt = '0;
        end
        pass_nxt = '0;
      end
      pcc_pkg::OP_VSTEP: begin
        // on a victim hold ptr so the tag read lands for the writeback
        if (!victim_now) begin
          if (use_r[ptr_r] && clearing) use_nxt[ptr_r] = 1'b0;
          ptr_nxt = ptr_circ;
          if (ptr_circ == start_r) pass_nxt = pass_r + 2'd1;
        end
      end
      pcc_pkg::OP_FSTART: begin
        ptr_nxt = '0;
      end
      pcc_pkg::OP_FSCAN: begin
        if (!dv[ptr_r]) ptr_nxt = ptr_r + SW'(1);
      end
      pcc_pkg::OP_FEMIT: begin
        dirty_nxt[ptr_r] = 1'b0;
        ptr_nxt          = ptr_r + SW'(1);
        out_valid_nxt    = 1'b1;
        out_hit_nxt      = 1'b0;
        out_slot_nxt     = SLOT_W'(ptr_r);
        out_fill_nxt     = 1'b0;
        out_wbv_nxt      = 1'b1;
        out_wbp_nxt      = PAGE_W'(tag_q);
        out_last_nxt     = (dv_rest == '0);
      end
      pcc_pkg::OP_FEMPTY, pcc_pkg::OP_FCLEAR: begin
        valid_nxt = '0;
        use_nxt   = '0;
        dirty_nxt = '0;
        hand_nxt  = '0;
        if (op == pcc_pkg::OP_FEMPTY) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b0;
          out_slot_nxt  = '0;
          out_fill_nxt  = 1'b0;
          out_wbv_nxt   = 1'b0;
          out_wbp_nxt   = '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // tag memory: read at ptr every cycle, written on fill
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[ptr_r];
    if (mem_we) tag_mem[mem_waddr] <= page_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      use_r        <= '0;
      dirty_r      <= '0;
      hand_r       <= '0;
      ptr_r        <= '0;
      start_r      <= '0;
      pass_r       <= '0;
      free_found_r <= 1'b0;
      cmp_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      use_r        <= use_nxt;
      dirty_r      <= dirty_nxt;
      hand_r       <= hand_nxt;
      ptr_r        <= ptr_nxt;
      start_r      <= start_nxt;
      pass_r       <= pass_nxt;
      free_found_r <= free_found_nxt;
      cmp_en_r     <= cmp_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r     <= free_nxt;
    page_r     <= page_nxt;
    write_r    <= write_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_hit_r  <= out_hit_nxt;
    out_slot_r <= out_slot_nxt;
    out_fill_r <= out_fill_nxt;
    out_wbv_r  <= out_wbv_nxt;
    out_wbp_r  <= out_wbp_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_slot            = out_slot_r;
  assign out_fill_needed     = out_fill_r;
  assign out_writeback_valid = out_wbv_r;
  assign out_writeback_page  = out_wbp_r;
  assign out_last            = out_last_r;

endmodule

// File: rtl/core/page_cache_clock_replacement.sv
// Lookup: a hit ends the scan at its slot; a miss scans all SLOTS slots, then fills a free
//   slot in the window or, with none free, steps the hand to a victim (up to 4 passes).
// Flush: scans slots up to the last dirty one, emits one result per dirty page, then clears;
//   with nothing dirty a single result is given and busy stays low.
// Throughput: one request at a time under busy; out_valid strobes, no receiver stall.
// Synchronous reset clears valid/use/dirty bits and the hand; the tag memory is not cleared.
// ----------------------------------------------------------------------------
// page_cache_clock_replacement
// Fully associative page tag store with CLOCK / enhanced CLOCK-M replacement.
// ----------------------------------------------------------------------------
module page_cache_clock_replacement #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcc_pkg::CMD_W-1:0]     in_command,
  input  logic [pcc_pkg::PAGE_W-1:0]    in_page_number,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [pcc_pkg::SLOT_W-1:0]    out_slot,
  output logic                          out_fill_needed,
  output logic                          out_writeback_valid,
  output logic [pcc_pkg::PAGE_W-1:0]    out_writeback_page,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CNT_W = pcc_pkg::CNT_W;

  logic                 mode_r, mode_nxt;
  logic [CNT_W-1:0]     slots_r, slots_nxt;
  logic                 reg_wr;
  pcc_pkg::dp_op_t      op;
  pcc_pkg::dp_status_t  status;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_comb begin
    mode_nxt  = mode_r;
    slots_nxt = slots_r;
    if (reg_wr) begin
      unique case (paddr[2])
        pcc_pkg::REG_MODE:  mode_nxt  = pwdata[0];
        pcc_pkg::REG_SLOTS: slots_nxt = pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pcc_pkg::REG_MODE:  prdata = {31'd0, mode_r};
      pcc_pkg::REG_SLOTS: prdata = {{(32-CNT_W){1'b0}}, slots_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pcc_pkg::MODE_CLOCK;
      slots_r <= CNT_W'(16);
    end else begin
      mode_r  <= mode_nxt;
      slots_r <= slots_nxt;
    end
  end

  pcc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .op         (op),
    .busy       (busy)
  );

  pcc_dp #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .in_command          (in_command),
    .in_page_number      (in_page_number),
    .cfg_mode            (mode_r),
    .cfg_slots           (slots_r),
    .status              (status),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_fill_needed     (out_fill_needed),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_page  (out_writeback_page),
    .out_last            (out_last)
  );

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page cache tag store with CLOCK / CLOCK-M
// replacement. A tracker class mirrors the tag, valid, use and dirty state
// and the clock hand, predicts the reply (or flush writeback run) for every
// accepted request, and checks each reply strobe in order. Stimulus is a
// short directed run, then random traffic over several mode, window size and
// sender idling settings. Registers are only written while the block is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int          NSLOT      = 16;
  localparam int          SETTLE     = 120;
  localparam int          CYCLE_CAP  = 500000;
  localparam int          POOL_DEPTH = 32;
  localparam logic [2:0]  ADDR_MODE  = {REG_MODE, 2'b00};
  localparam logic [2:0]  ADDR_SLOTS = {REG_SLOTS, 2'b00};

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              fill;
    logic              wb_valid;
    logic [PAGE_W-1:0] wb_page;
    logic              last;
  } cache_reply_t;

  class tag_tracker;
    logic [PAGE_W-1:0] tag[NSLOT];
    bit                vld[NSLOT];
    bit                used[NSLOT];
    bit                dirty[NSLOT];
    int                hand;
    bit                mode_m;
    logic [CNT_W-1:0]  win_reg;
    cache_reply_t      due_replies[$];
    int                requests;
    int                replies;
    int                mismatches;
    int                flushes;
    int                evictions;
    int                hits;

    function new();
      foreach (vld[i]) begin
        vld[i] = 0;
        used[i] = 0;
        dirty[i] = 0;
        tag[i] = '0;
      end
      hand = 0;
      mode_m = MODE_CLOCK;
      win_reg = CNT_W'(NSLOT);
      requests = 0;
      replies = 0;
      mismatches = 0;
      flushes = 0;
      evictions = 0;
      hits = 0;
    endfunction

    function int window();
      int n;
      n = win_reg;
      if (n < 1) n = 1;
      if (n > NSLOT) n = NSLOT;
      return n;
    endfunction

    function int pick_victim(int n);
      int passes;
      int first;
      int s;
      bit sweep;
      passes = mode_m ? 4 : 2;
      first = (hand < n) ? hand : 0;
      for (int p = 0; p < passes; p++) begin
        // CLOCK-M: odd passes clear use bits, even passes want clean pages
        sweep = !mode_m || (p % 2 == 1);
        for (int i = 0; i < n; i++) begin
          s = (first + i) % n;
          if (!used[s]) begin
            if (!mode_m || !dirty[s] || sweep) return s;
          end else if (sweep) begin
            used[s] = 0;
          end
        end
      end
      return first;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
      cache_reply_t r;
      int total;
      int k;
      int n;
      int s;
      requests++;
      r = '0;
      if (cmd == CMD_NOP) return;
      if (cmd == CMD_FLUSH) begin
        flushes++;
        total = 0;
        foreach (vld[i]) if (vld[i] && dirty[i]) total++;
        k = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (vld[i] && dirty[i]) begin
            k++;
            r = '0;
            r.slot = SLOT_W'(i);
            r.wb_valid = 1'b1;
            r.wb_page = tag[i];
            r.last = (k == total);
            due_replies.push_back(r);
          end
          vld[i] = 0;
          used[i] = 0;
          dirty[i] = 0;
        end
        hand = 0;
        if (total == 0) begin
          r = '0;
          r.last = 1'b1;
          due_replies.push_back(r);
        end
        return;
      end
      r.last = 1'b1;
      for (int i = 0; i < NSLOT; i++) begin
        if (vld[i] && tag[i] == page) begin
          used[i] = 1;
          if (cmd == CMD_WRITE) dirty[i] = 1;
          r.hit = 1'b1;
          r.slot = SLOT_W'(i);
          due_replies.push_back(r);
          hits++;
          return;
        end
      end
      n = window();
      for (s = 0; s < n; s++) if (!vld[s]) break;
      if (s >= n) begin
        s = pick_victim(n);
        evictions++;
        if (dirty[s]) begin
          r.wb_valid = 1'b1;
          r.wb_page = tag[s];
        end
      end
      r.slot = SLOT_W'(s);
      r.fill = 1'b1;
      due_replies.push_back(r);
      tag[s] = page;
      vld[s] = 1;
      used[s] = 1;
      dirty[s] = (cmd == CMD_WRITE);
      hand = (s + 1) % n;
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t want;
      replies++;
      if (due_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: reply with nothing outstanding: ", $realtime);
          $display("hit=%0b slot=%0d fill=%0b wb=%0b/%05h last=%0b",
                   got.hit, got.slot, got.fill, got.wb_valid, got.wb_page, got.last);
        end
        return;
      end
      want = due_replies.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot || got.fill !== want.fill ||
          got.wb_valid !== want.wb_valid || got.wb_page !== want.wb_page ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: reply mismatch exp hit=%0b slot=%0d fill=%0b wb=%0b/%05h last=%0b",
                 $realtime, want.hit, want.slot, want.fill, want.wb_valid, want.wb_page,
                 want.last);
          $display(", got hit=%0b slot=%0d fill=%0b wb=%0b/%05h last=%0b",
                   got.hit, got.slot, got.fill, got.wb_valid, got.wb_page, got.last);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_command;
  logic [PAGE_W-1:0] in_page_number;
  logic              out_valid;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_fill_needed;
  logic              out_writeback_valid;
  logic [PAGE_W-1:0] out_writeback_page;
  logic              out_last;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  tag_tracker        tracker;
  logic [PAGE_W-1:0] page_pool[POOL_DEPTH];
  int                pool_span;
  int                idle_pct;
  int                cycle_count = 0;

  page_cache_clock_replacement u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_page_number      (in_page_number),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_fill_needed     (out_fill_needed),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_page  (out_writeback_page),
    .out_last            (out_last),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_reply('{out_hit, out_slot, out_fill_needed, out_writeback_valid,
                            out_writeback_page, out_last});
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // hold the request until the block takes it at a rising edge with busy low
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [PAGE_W-1:0] page);
    @(negedge clk);
    start = 1'b1;
    in_command = cmd;
    in_page_number = page;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    tracker.note_request(cmd, page);
  endtask

  task automatic rest_cycle();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    rest_cycle();
    while (tracker.due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drain, let a flush finish the clear that follows its last reply, then reprogram
  task automatic apply_setting(logic mode, logic [CNT_W-1:0] win);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_write(ADDR_MODE, {31'd0, mode});
    tracker.mode_m = mode;
    cfg_write(ADDR_SLOTS, {27'd0, win});
    tracker.win_reg = win;
  endtask

  task automatic random_phase(logic mode, logic [CNT_W-1:0] win, int pct, int count,
                              bit drain_midway);
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page;
    int                pick;
    apply_setting(mode, win);
    idle_pct = pct;
    pool_span = tracker.window() + tracker.window() / 2 + 2;
    if (pool_span > POOL_DEPTH) pool_span = POOL_DEPTH;
    for (int i = 0; i < count; i++) begin
      while ($urandom_range(99) < idle_pct) rest_cycle();
      if (drain_midway && i == count / 2) wait_drained();
      pick = $urandom_range(99);
      if (pick < 46) cmd = CMD_READ;
      else if (pick < 91) cmd = CMD_WRITE;
      else if (pick < 97) cmd = CMD_FLUSH;
      else cmd = CMD_NOP;
      if ($urandom_range(99) < 85) page = page_pool[$urandom_range(pool_span - 1)];
      else page = PAGE_W'($urandom);
      send_request(cmd, page);
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_READ;
    in_page_number = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    pool_span = 1;
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_DEPTH; i++) page_pool[i] = PAGE_W'($urandom);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // hit, miss, write-hit, ignored command, dirty and clean flushes
    send_request(CMD_READ, 20'h00000);
    send_request(CMD_WRITE, 20'hFFFFF);
    send_request(CMD_READ, 20'h00000);
    send_request(CMD_WRITE, 20'h00000);
    send_request(CMD_NOP, 20'h5A5A5);
    send_request(CMD_FLUSH, 20'hFFFFF);
    send_request(CMD_FLUSH, 20'h00000);

    // two-slot window under CLOCK-M: dirty victims skipped, use bits swept
    apply_setting(MODE_CLOCK_M, 5'd2);
    send_request(CMD_WRITE, 20'h00001);
    send_request(CMD_READ, 20'h00002);
    send_request(CMD_READ, 20'h00003);
    send_request(CMD_WRITE, 20'h00004);
    send_request(CMD_READ, 20'h00003);
    send_request(CMD_READ, 20'h00005);
    send_request(CMD_WRITE, 20'h00006);
    send_request(CMD_FLUSH, 20'h00000);

    // single slot under plain CLOCK: every miss after the first evicts
    apply_setting(MODE_CLOCK, 5'd1);
    send_request(CMD_WRITE, 20'h00007);
    send_request(CMD_READ, 20'h00008);
    send_request(CMD_READ, 20'h00008);
    send_request(CMD_WRITE, 20'h00009);
    send_request(CMD_FLUSH, 20'h00000);

    random_phase(MODE_CLOCK,   5'd16, 0,  30, 1'b0);
    random_phase(MODE_CLOCK_M, 5'd16, 84, 30, 1'b0);
    random_phase(MODE_CLOCK_M, 5'd4,  35, 30, 1'b1);
    random_phase(MODE_CLOCK,   5'd1,  0,  30, 1'b0);
    random_phase(MODE_CLOCK_M, 5'd0,  84, 30, 1'b0);
    random_phase(MODE_CLOCK,   5'd31, 35, 30, 1'b1);
    random_phase(MODE_CLOCK_M, 5'd8,  0,  30, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("run: %0d requests, %0d replies, %0d hits, %0d evictions, %0d flushes",
             tracker.requests, tracker.replies, tracker.hits, tracker.evictions,
             tracker.flushes);
    $display("run: CLOCK and CLOCK-M, windows 0/1/2/4/8/16/31, sender idling 0/35/84 pct");
    if (tracker.mismatches == 0 && tracker.due_replies.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("run: %0d mismatches, %0d replies never seen", tracker.mismatches,
               tracker.due_replies.size());
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_ctrl.sv
rtl/core/pcc_dp.sv
rtl/core/page_cache_clock_replacement.sv
dv/tb_top.sv
